// File: hw/rtl/urc_pkg.sv
// Package for the UART register capture block: beat types, controller
// command and status structs, op codes, register offsets and constants.
// No dependencies.
package urc_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam logic [2:0] OFF_DATA = 3'd0;
  localparam logic [2:0] OFF_IER  = 3'd1;
  localparam logic [2:0] OFF_LCR  = 3'd3;
  localparam logic [2:0] OFF_LSR  = 3'd5;

  localparam logic [7:0] LSR_VALUE = 8'h60;
  localparam int         DLAB_BIT  = 7;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
  } urc_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] drained_char;
    logic       drained_valid;
    logic [6:0] drained_count;
    logic       last;
  } urc_out_t;

  typedef struct packed {
    logic accept;
    logic read_next;
    logic load_char;
  } urc_cmd_t;

  typedef struct packed {
    logic fill_empty;
    logic drain_more;
  } urc_sts_t;

endpackage

// File: hw/rtl/urc_ctrl.sv
// Controller state machine of the UART register capture block.
// Sequences register accesses and drain reads; depends on urc_pkg.
module urc_ctrl
  import urc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_is_drain,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  urc_sts_t sts,
  output urc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;
  logic       read_next;
  logic [1:0] accept_state;

  always_comb begin
    in_stall     = !((state_r == S_IDLE) ||
                     ((state_r == S_SEND) && !out_stall && !sts.drain_more));
    accept       = in_valid && !in_stall;
    read_next    = (state_r == S_SEND) && !out_stall && sts.drain_more;
    accept_state = (in_is_drain && !sts.fill_empty) ? S_READ : S_SEND;
    out_valid    = (state_r == S_SEND);
    cmd.accept    = accept;
    cmd.read_next = read_next;
    cmd.load_char = (state_r == S_READ);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = accept_state;
        end
      end
      S_READ: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (read_next) begin
          state_nxt = S_READ;
        end else if (accept) begin
          state_nxt = accept_state;
        end else if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/urc_dp.sv
// Datapath of the UART register capture block: emulated registers, the
// capture memory, drain counters and the result register; depends on urc_pkg.
module urc_dp
  import urc_pkg::*;
#(
  parameter int CAPTURE_DEPTH = 64
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  urc_in_t  in_beat,
  input  urc_cmd_t cmd,
  output urc_sts_t sts,
  output urc_out_t out_beat
);

  localparam int FW = $clog2(CAPTURE_DEPTH + 1);
  localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;

  logic          emu_r;
  logic [7:0]    dll_r;
  logic [7:0]    dlh_r;
  logic [7:0]    lcr_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] idx_r;
  logic [FW-1:0] cnt_r;
  logic [7:0]    mem [CAPTURE_DEPTH];
  logic [7:0]    mem_q_r;
  urc_out_t      out_r;
  urc_out_t      out_nxt;

  logic          dlab;
  logic [7:0]    rd_val;
  logic          reg_wr;
  logic          mem_we;
  logic          mem_re;
  logic          start;
  logic [AW-1:0] rd_addr;
  logic          fin;

  always_comb begin
    dlab = lcr_r[DLAB_BIT];
    rd_val = 8'h00;
    if (emu_r) begin
      case (in_beat.reg_offset)
        OFF_DATA: rd_val = dlab ? dll_r : 8'h00;
        OFF_IER:  rd_val = dlab ? dlh_r : 8'h00;
        OFF_LCR:  rd_val = lcr_r;
        OFF_LSR:  rd_val = LSR_VALUE;
        default:  rd_val = 8'h00;
      endcase
    end
    reg_wr  = cmd.accept && emu_r && (in_beat.op == OP_WRITE);
    mem_we  = reg_wr && (in_beat.reg_offset == OFF_DATA) && !dlab &&
              (fill_r < FW'(CAPTURE_DEPTH));
    start   = cmd.accept && (in_beat.op == OP_DRAIN) && (fill_r != '0);
    mem_re  = start || cmd.read_next;
    rd_addr = start ? '0 : idx_r[AW-1:0];
    fin     = ((idx_r + FW'(1)) == cnt_r);
    sts.fill_empty = (fill_r == '0);
    sts.drain_more = (idx_r != cnt_r);
    out_nxt = out_r;
    if (cmd.accept) begin
      out_nxt      = '0;
      out_nxt.last = 1'b1;
      if (in_beat.op == OP_READ) begin
        out_nxt.read_data = rd_val;
      end
    end else if (cmd.load_char) begin
      out_nxt.read_data     = 8'h00;
      out_nxt.drained_char  = mem_q_r;
      out_nxt.drained_valid = 1'b1;
      out_nxt.drained_count = fin ? 7'(cnt_r) : 7'd0;
      out_nxt.last          = fin;
    end
    out_beat = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emu_r  <= 1'b1;
      dll_r  <= 8'h00;
      dlh_r  <= 8'h00;
      lcr_r  <= 8'h00;
      fill_r <= '0;
      idx_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        emu_r <= cfg_wdata;
      end
      if (reg_wr) begin
        case (in_beat.reg_offset)
          OFF_DATA: begin
            if (dlab) begin
              dll_r <= in_beat.write_data;
            end
          end
          OFF_IER: begin
            if (dlab) begin
              dlh_r <= in_beat.write_data;
            end
          end
          OFF_LCR: begin
            lcr_r <= in_beat.write_data;
          end
          default: begin
          end
        endcase
      end
      if (mem_we) begin
        fill_r <= fill_r + FW'(1);
      end
      if (start) begin
        cnt_r  <= fill_r;
        idx_r  <= '0;
        fill_r <= '0;
      end else if (cmd.load_char) begin
        idx_r <= idx_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= in_beat.write_data;
    end
    if (mem_re) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// File: hw/rtl/uart_register_capture.sv
// Top level of the UART register capture block; instantiates urc_ctrl and
// urc_dp and depends on urc_pkg.
// Register access: result registered in the cycle after the input beat; one
// beat a cycle when the result side does not stall. Drain: each byte is read
// into a register, then the result register, and is taken before the next
// is read. Synchronous active-low reset clears registers and fill count.
module uart_register_capture
  import urc_pkg::*;
#(
  parameter int CAPTURE_DEPTH = 64
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_stall,
  input  urc_in_t  in_beat,
  output logic     out_valid,
  input  logic     out_stall,
  output urc_out_t out_beat
);

  urc_cmd_t cmd;
  urc_sts_t sts;

  urc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_is_drain (in_beat.op == OP_DRAIN),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  urc_dp #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .sts       (sts),
    .out_beat  (out_beat)
  );

endmodule
